// File: sv/hdr_exposure_knee_gamma_tonemap_top_defines.svh
// Assertion macros shared by the tone mapper RTL
`ifndef HDR_EXPOSURE_KNEE_GAMMA_TONEMAP_TOP_DEFINES_SVH
`define HDR_EXPOSURE_KNEE_GAMMA_TONEMAP_TOP_DEFINES_SVH

// Same-cycle implication, checked only out of reset
`define TMAP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only out of reset
`define TMAP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tmap_pkg.sv
// Shared types, constants and table builders of the tone mapper
package tmap_pkg;

  localparam logic [31:0] QMAX    = 32'hFFFF_FFFF;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FORMAT      = 3'd0,
    REG_DEFOG       = 3'd1,
    REG_EXPOSURE    = 3'd2,
    REG_KNEE_LOW    = 3'd3,
    REG_KNEE_FACTOR = 3'd4,
    REG_INV_GAMMA   = 3'd5,
    REG_OUT_SCALE   = 3'd6
  } reg_idx_t;

  // Configuration seen by every channel
  typedef struct packed {
    logic        fmt;
    logic [31:0] defog;
    logic [31:0] expo;
    logic [31:0] knee_low;
    logic [31:0] knee_fac;
    logic [31:0] inv_gamma;
    logic [31:0] out_scale;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fmt:       1'b0,
    defog:     32'd0,
    expo:      32'd364089,
    knee_low:  32'd65536,
    knee_fac:  32'd12124,
    inv_gamma: 32'd29789,
    out_scale: 32'd5547600
  };

  // Cycles from a pixel entering a channel to its byte leaving it
  function automatic int chan_lat(input int f);
    return 2 * f + 29;
  endfunction

  // Integer square root, one result bit per step
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xr;
    logic [63:0] r;
    logic [63:0] b;
    xr = x;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (xr >= r + b) begin
        xr = xr - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // log2(1 + i / 2^tb) in Q0.30 by repeated squaring
  function automatic logic [31:0] log_entry(input int tb, input int i);
    logic [63:0] m;
    logic [31:0] acc;
    if (i == (1 << tb)) return 32'h4000_0000;
    m   = 64'h4000_0000 + (64'(i) << (30 - tb));
    acc = '0;
    for (int k = 0; k < 30; k++) begin
      m   = (m * m) >> 30;
      acc = acc << 1;
      if (m >= 64'h8000_0000) begin
        acc[0] = 1'b1;
        m      = m >> 1;
      end
    end
    return acc;
  endfunction

  // 2^(i / 2^tb) in Q1.30 from products of repeated roots of two
  function automatic logic [31:0] exp_entry(input int tb, input int i);
    logic [63:0] root [13];
    logic [63:0] e;
    if (i == (1 << tb)) return 32'h8000_0000;
    root[0] = 64'h8000_0000;
    for (int k = 1; k < 13; k++) begin
      if (k <= tb) root[k] = isqrt64(root[k-1] << 30);
      else root[k] = '0;
    end
    e = 64'h4000_0000;
    for (int j = 0; j < 12; j++) begin
      if (j < tb && ((i >> j) & 1) == 1) e = (e * root[tb-j]) >> 30;
    end
    return e[31:0];
  endfunction

endpackage

// File: sv/tmap_log2.sv
// Four-stage log2 of a Q value: leading one, table read, interpolate, assemble
module tmap_log2 #(
  parameter int FRAC  = 16,
  parameter int TBITS = 8
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [31:0]            x_i,
  output logic signed [FRAC+5:0] lg_o
);

  localparam int TAB_N = (1 << TBITS) + 1;
  localparam int SH    = 30 - TBITS;
  localparam int IW    = TBITS + 1;

  function automatic logic [TAB_N-1:0][31:0] build_log();
    logic [TAB_N-1:0][31:0] t;
    for (int i = 0; i < TAB_N; i++) t[i] = tmap_pkg::log_entry(TBITS, i);
    return t;
  endfunction

  localparam logic [TAB_N-1:0][31:0] LOG_TAB = build_log();

  logic [4:0]    p_nxt;
  logic [31:0]   x1_r;
  logic [4:0]    p1_r;
  logic [31:0]   m;
  logic [IW-1:0] idx0;
  logic [IW-1:0] idx1;
  logic [31:0]   t0;
  logic [31:0]   t1;
  logic [31:0]   t0_2_r;
  logic [31:0]   d_2_r;
  logic [SH-1:0] r_2_r;
  logic [4:0]    p2_r;
  logic [31+SH:0] prod;
  logic [31:0]   t0_3_r;
  logic [31:0]   ps_3_r;
  logic [4:0]    p3_r;
  logic [31:0]   lf;
  logic [6:0]    pm;

  // Find the leading one
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 32; i++) if (x_i[i]) p_nxt = 5'(i);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= x_i;
      p1_r <= p_nxt;
    end
  end

  // Normalize and read both table neighbors
  always_comb begin
    m    = (p1_r == 5'd31) ? (x1_r >> 1) : (x1_r << (5'd30 - p1_r));
    idx0 = {1'b0, m[29 -: TBITS]};
    idx1 = idx0 + IW'(1);
    t0   = LOG_TAB[idx0];
    t1   = LOG_TAB[idx1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_2_r <= t0;
      d_2_r  <= t1 - t0;
      r_2_r  <= m[SH-1:0];
      p2_r   <= p1_r;
    end
  end

  // Interpolate on the remaining mantissa bits
  assign prod = {{SH{1'b0}}, d_2_r} * {32'd0, r_2_r};

  always_ff @(posedge clk) begin
    if (en) begin
      t0_3_r <= t0_2_r;
      ps_3_r <= prod[SH +: 32];
      p3_r   <= p2_r;
    end
  end

  // Join integer part and fraction
  always_comb begin
    lf = t0_3_r + ps_3_r;
    pm = {2'b00, p3_r} - 7'(FRAC);
  end

  always_ff @(posedge clk) begin
    if (en) lg_o <= $signed({pm[5:0], lf[29 -: FRAC]});
  end

endmodule

// File: sv/tmap_exp2.sv
// Three-stage exp2 of a signed fixed-point exponent to a saturated Q value
module tmap_exp2 #(
  parameter int FRAC  = 16,
  parameter int TBITS = 8
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [37:0] q_i,
  output logic [31:0]        e_o
);

  localparam int TAB_N = (1 << TBITS) + 1;
  localparam int SH    = 30 - TBITS;
  localparam int IW    = TBITS + 1;

  function automatic logic [TAB_N-1:0][31:0] build_exp();
    logic [TAB_N-1:0][31:0] t;
    for (int i = 0; i < TAB_N; i++) t[i] = tmap_pkg::exp_entry(TBITS, i);
    return t;
  endfunction

  localparam logic [TAB_N-1:0][31:0] EXP_TAB = build_exp();

  logic signed [37:0] n;
  logic [29:0]    frac30;
  logic [IW-1:0]  idx0;
  logic [IW-1:0]  idx1;
  logic [31:0]    t0;
  logic [31:0]    t1;
  logic [31:0]    t0_1_r;
  logic [31:0]    d_1_r;
  logic [SH-1:0]  r_1_r;
  logic [7:0]     s_1_r;
  logic           sat_1_r;
  logic           zro_1_r;
  logic [31+SH:0] prod;
  logic [31:0]    t0_2_r;
  logic [31:0]    ps_2_r;
  logic [7:0]     s_2_r;
  logic           sat_2_r;
  logic           zro_2_r;
  logic [31:0]    mant;
  logic [71:0]    wide;
  logic [7:0]     ns;
  logic [31:0]    e_nxt;

  // Split integer and fraction, read both table neighbors
  always_comb begin
    n      = q_i >>> FRAC;
    frac30 = {q_i[FRAC-1:0], {(30-FRAC){1'b0}}};
    idx0   = {1'b0, frac30[29 -: TBITS]};
    idx1   = idx0 + IW'(1);
    t0     = EXP_TAB[idx0];
    t1     = EXP_TAB[idx1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_1_r  <= t0;
      d_1_r   <= t1 - t0;
      r_1_r   <= frac30[SH-1:0];
      s_1_r   <= n[7:0] + 8'(FRAC - 30);
      sat_1_r <= n > 38'sd40;
      zro_1_r <= n < -38'sd80;
    end
  end

  // Interpolate
  assign prod = {{SH{1'b0}}, d_1_r} * {32'd0, r_1_r};

  always_ff @(posedge clk) begin
    if (en) begin
      t0_2_r  <= t0_1_r;
      ps_2_r  <= prod[SH +: 32];
      s_2_r   <= s_1_r;
      sat_2_r <= sat_1_r;
      zro_2_r <= zro_1_r;
    end
  end

  // Scale the mantissa by the integer part, saturate
  always_comb begin
    mant = t0_2_r + ps_2_r;
    wide = 72'(mant) << s_2_r[5:0];
    ns   = -s_2_r;
    if (sat_2_r) e_nxt = tmap_pkg::QMAX;
    else if (zro_2_r) e_nxt = '0;
    else if (!s_2_r[7]) e_nxt = (wide[71:32] != '0) ? tmap_pkg::QMAX : wide[31:0];
    else if (ns >= 8'd32) e_nxt = '0;
    else e_nxt = mant >> ns[4:0];
  end

  always_ff @(posedge clk) begin
    if (en) e_o <= e_nxt;
  end

endmodule

// File: sv/tmap_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturated to 32 bits
module tmap_div #(
  parameter int NW = 37
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_i,
  input  logic [31:0]   den_i,
  output logic [31:0]   quo_o
);

  logic [31:0]   rem_r [NW];
  logic [NW-1:0] nq_r  [NW];
  logic [63:0]   q64;

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic [31:0]   rem_in;
    logic [NW-1:0] nq_in;
    logic [32:0]   rs;
    logic          ge;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = num_i;
    end else begin : g_rest
      assign rem_in = rem_r[g-1];
      assign nq_in  = nq_r[g-1];
    end

    // Shift in the next numerator bit and try the subtraction
    always_comb begin
      rs = {rem_in, nq_in[NW-1]};
      ge = rs >= {1'b0, den_i};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= ge ? 32'(rs - {1'b0, den_i}) : rs[31:0];
        nq_r[g]  <= {nq_in[NW-2:0], ge};
      end
    end
  end

  // Saturate the quotient
  always_comb begin
    q64   = 64'(nq_r[NW-1]);
    quo_o = (q64[63:32] != '0) ? tmap_pkg::QMAX : q64[31:0];
  end

endmodule

// File: sv/tmap_chan.sv
// One channel of the tone mapper: decode, defog, exposure, knee, gamma, scale
module tmap_chan #(
  parameter int FRAC  = 16,
  parameter int TBITS = 8
) (
  input  logic              clk,
  input  logic              en,
  input  tmap_pkg::cfg_t    cfg_i,
  input  logic [31:0]       bits_i,
  output logic [7:0]        byte_o
);

  localparam int NW  = 2 * FRAC + 5;
  localparam int KD  = NW + 6;
  localparam int PW  = FRAC + 37;
  localparam logic [31:0] QONE = 32'd1 << FRAC;

  typedef struct packed {
    logic [31:0] v;
    logic        knee;
    logic [31:0] t;
  } knee_side_t;

  // Place a significand at a binary shift, saturating
  function automatic logic [31:0] to_q(input logic [23:0] sig, input logic signed [9:0] sh);
    logic [63:0] wide;
    logic [9:0]  nsh;
    wide = 64'(sig) << sh[4:0];
    nsh  = -sh;
    if (sig == '0) return '0;
    if (sh >= 10'sd32) return tmap_pkg::QMAX;
    if (sh >= 10'sd0) return (wide[63:32] != '0) ? tmap_pkg::QMAX : wide[31:0];
    if (sh <= -10'sd32) return '0;
    return 32'(sig) >> nsh[4:0];
  endfunction

  logic [31:0] dec;
  logic [31:0] v1_r;
  logic [31:0] v2_r;
  logic [63:0] p3_r;
  logic [63:0] sh4;
  logic [31:0] v4;
  logic [31:0] v4_r;
  logic        k4_r;
  logic [31:0] t4_r;
  logic [63:0] p5_r;
  logic [31:0] v5_r;
  logic        k5_r;
  logic [31:0] t5_r;
  logic [63:0] sh6;
  logic [31:0] a6;
  logic [31:0] u6_r;
  knee_side_t  side6_r;
  knee_side_t  ks_r [KD];
  logic signed [FRAC+5:0] klg;
  logic [PW-1:0] p11_r;
  logic [NW-1:0] num12_r;
  logic [31:0] quo;
  knee_side_t  ks_last;
  logic [31:0] kn;
  logic [32:0] ksum;
  logic [31:0] vk_r;
  logic signed [FRAC+5:0] glg;
  logic [8:0]  nz_r;
  logic [FRAC+5:0] magw;
  logic [PW-1:0] pm_r;
  logic        neg_r;
  logic [37:0] pr38;
  logic signed [37:0] q_r;
  logic [31:0] ge;
  logic [63:0] po_r;
  logic [63:0] w;
  logic [7:0]  byte_r;

  // Decode the float pattern to a Q value
  always_comb begin
    dec = '0;
    if (!cfg_i.fmt) begin
      if (bits_i[14:10] == 5'd31) begin
        dec = (bits_i[9:0] != '0 || bits_i[15]) ? '0 : tmap_pkg::QMAX;
      end else if (bits_i[15]) begin
        dec = '0;
      end else if (bits_i[14:10] == 5'd0) begin
        dec = to_q({14'd0, bits_i[9:0]}, 10'(FRAC) - 10'd24);
      end else begin
        dec = to_q({13'd0, 1'b1, bits_i[9:0]}, 10'(bits_i[14:10]) + 10'(FRAC) - 10'd25);
      end
    end else begin
      if (bits_i[30:23] == 8'd255) begin
        dec = (bits_i[22:0] != '0 || bits_i[31]) ? '0 : tmap_pkg::QMAX;
      end else if (bits_i[31]) begin
        dec = '0;
      end else if (bits_i[30:23] == 8'd0) begin
        dec = to_q({1'b0, bits_i[22:0]}, 10'(FRAC) - 10'd149);
      end else begin
        dec = to_q({1'b1, bits_i[22:0]}, 10'(bits_i[30:23]) + 10'(FRAC) - 10'd150);
      end
    end
  end

  // Saturating shifts of the exposure and knee products
  always_comb begin
    sh4 = p3_r >> FRAC;
    v4  = (sh4[63:32] != '0) ? tmap_pkg::QMAX : sh4[31:0];
    sh6 = p5_r >> FRAC;
    a6  = (sh6[63:32] != '0) ? tmap_pkg::QMAX : sh6[31:0];
  end

  // Decode, defog, exposure and knee front end
  always_ff @(posedge clk) begin
    if (en) begin
      v1_r    <= dec;
      v2_r    <= (v1_r > cfg_i.defog) ? v1_r - cfg_i.defog : '0;
      p3_r    <= 64'(v2_r) * 64'(cfg_i.expo);
      v4_r    <= v4;
      k4_r    <= v4 > cfg_i.knee_low;
      t4_r    <= v4 - cfg_i.knee_low;
      p5_r    <= 64'(t4_r) * 64'(cfg_i.knee_fac);
      v5_r    <= v4_r;
      k5_r    <= k4_r;
      t5_r    <= t4_r;
      u6_r    <= (a6 > tmap_pkg::QMAX - QONE) ? tmap_pkg::QMAX : a6 + QONE;
      side6_r <= '{v: v5_r, knee: k5_r, t: t5_r};
    end
  end

  tmap_log2 #(.FRAC(FRAC), .TBITS(TBITS)) u_knee_log (
    .clk  (clk),
    .en   (en),
    .x_i  (u6_r),
    .lg_o (klg)
  );

  // Hold the pre-knee value alongside the log and divide
  always_ff @(posedge clk) begin
    if (en) begin
      ks_r[0] <= side6_r;
      for (int k = 1; k < KD; k++) ks_r[k] <= ks_r[k-1];
    end
  end

  // Natural log and numerator of the knee quotient
  always_ff @(posedge clk) begin
    if (en) begin
      p11_r   <= PW'(klg[FRAC+4:0]) * PW'(tmap_pkg::LN2_Q32);
      num12_r <= {p11_r[32 +: FRAC+5], {FRAC{1'b0}}};
    end
  end

  tmap_div #(.NW(NW)) u_div (
    .clk   (clk),
    .en    (en),
    .num_i (num12_r),
    .den_i (cfg_i.knee_fac),
    .quo_o (quo)
  );

  // Add the knee curve back onto the knee-low level
  always_comb begin
    ks_last = ks_r[KD-1];
    kn      = (cfg_i.knee_fac == '0) ? ks_last.t : quo;
    ksum    = 33'(cfg_i.knee_low) + 33'(kn);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ks_last.knee) vk_r <= ksum[32] ? tmap_pkg::QMAX : ksum[31:0];
      else vk_r <= ks_last.v;
    end
  end

  tmap_log2 #(.FRAC(FRAC), .TBITS(TBITS)) u_gamma_log (
    .clk  (clk),
    .en   (en),
    .x_i  (vk_r),
    .lg_o (glg)
  );

  // Scale the log by the inverse gamma
  always_comb begin
    magw = glg[FRAC+5] ? -glg : glg;
    pr38 = {1'b0, pm_r[FRAC +: 37]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nz_r  <= {nz_r[7:0], vk_r != '0};
      pm_r  <= PW'(magw[FRAC+4:0]) * PW'(cfg_i.inv_gamma);
      neg_r <= glg[FRAC+5];
      q_r   <= $signed(neg_r ? -pr38 : pr38);
    end
  end

  tmap_exp2 #(.FRAC(FRAC), .TBITS(TBITS)) u_exp (
    .clk (clk),
    .en  (en),
    .q_i (q_r),
    .e_o (ge)
  );

  // Output scale and byte clamp
  assign w = po_r >> (2 * FRAC);

  always_ff @(posedge clk) begin
    if (en) begin
      po_r   <= 64'(nz_r[8] ? ge : 32'd0) * 64'(cfg_i.out_scale);
      byte_r <= (w[63:8] != '0) ? 8'hFF : w[7:0];
    end
  end

  assign byte_o = byte_r;

endmodule

// File: sv/hdr_exposure_knee_gamma_tonemap_top.sv
// Top level of the HDR exposure, knee and gamma tone mapper
//
// Takes one four-channel HDR pixel per clock while the pipe advances and
// returns one byte per channel for each pixel. The knee divider, a restoring
// divider of 2*FRACTION_BITS+5 pipeline stages, makes up most of the pipe;
// the two log2 units and the exp2 unit add their own stages. The whole
// pipe advances together when its output register is empty or taken, and a
// one-entry skid buffer at the input lets one more pixel in while a result
// waits. Registers are to be written only while the pipe is empty; the block
// itself does not enforce this, and there is no clearing pass after reset.
`include "hdr_exposure_knee_gamma_tonemap_top_defines.svh"

module hdr_exposure_knee_gamma_tonemap_top #(
  parameter int FRACTION_BITS  = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // red_in, green_in, blue_in, alpha_in
  input  logic         in_tlast,   // end_of_image
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic         out_tlast   // last_out
);

  localparam int LAT = tmap_pkg::chan_lat(FRACTION_BITS);

  tmap_pkg::cfg_t cfg_r;
  logic           skid_v_r;
  logic [127:0]   skid_d_r;
  logic           skid_l_r;
  logic           adv;
  logic           pv;
  logic [127:0]   pd;
  logic           pl;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] last_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= tmap_pkg::CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tmap_pkg::REG_FORMAT:      cfg_r.fmt       <= cfg_wdata[0];
        tmap_pkg::REG_DEFOG:       cfg_r.defog     <= cfg_wdata;
        tmap_pkg::REG_EXPOSURE:    cfg_r.expo      <= cfg_wdata;
        tmap_pkg::REG_KNEE_LOW:    cfg_r.knee_low  <= cfg_wdata;
        tmap_pkg::REG_KNEE_FACTOR: cfg_r.knee_fac  <= cfg_wdata;
        tmap_pkg::REG_INV_GAMMA:   cfg_r.inv_gamma <= cfg_wdata;
        tmap_pkg::REG_OUT_SCALE:   cfg_r.out_scale <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the pipe when the output register frees up
  assign adv       = ~vld_r[LAT-1] | out_tready;
  assign in_tready = ~skid_v_r;
  assign pv        = skid_v_r | in_tvalid;
  assign pd        = skid_v_r ? skid_d_r : in_tdata;
  assign pl        = skid_v_r ? skid_l_r : in_tlast;

  // Park one request in the skid buffer while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (adv) begin
      skid_v_r <= 1'b0;
    end else if (in_tvalid && !skid_v_r) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_v_r) begin
      skid_d_r <= in_tdata;
      skid_l_r <= in_tlast;
    end
  end

  // Valid and end-of-image bits travel with the channel data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], pv};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) last_r <= {last_r[LAT-2:0], pl};
  end

  for (genvar c = 0; c < 4; c++) begin : g_chan
    tmap_chan #(.FRAC(FRACTION_BITS), .TBITS(LOG_TABLE_BITS)) u_chan (
      .clk    (clk),
      .en     (adv),
      .cfg_i  (cfg_r),
      .bits_i (pd[32*c +: 32]),
      .byte_o (out_tdata[8*c +: 8])
    );
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tlast  = last_r[LAT-1];

  `TMAP_ASSERT_NEXT(a_skid_fills, in_tvalid && in_tready && !adv, skid_v_r, "stalled request not parked")
  `TMAP_ASSERT_NEXT(a_skid_holds, skid_v_r && !adv, skid_v_r, "parked request lost in stall")
  `TMAP_ASSERT_NOW(a_out_from_pipe, $rose(out_tvalid), $past(vld_r[LAT-2]), "result without request")

endmodule

// File: tb/hdr_exposure_knee_gamma_tonemap_top_tb.sv
// Testbench for the HDR exposure, knee and gamma tone mapper
`timescale 1ns / 1ps

module hdr_exposure_knee_gamma_tonemap_top_tb;

  localparam int          FB          = 16;
  localparam int          TB_BITS     = 8;
  localparam int          TAB_LEN     = (1 << TB_BITS) + 1;
  localparam int          PIPE_LAT    = 2 * FB + 29;
  localparam int          CYCLE_LIMIT = 1500000;
  localparam logic [2:0]  REG_UNUSED  = 3'd7;
  localparam logic [63:0] SAT_MAX     = 64'hFFFF_FFFF;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [31:0]  out_tdata;
  logic         out_tlast;

  hdr_exposure_knee_gamma_tonemap_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    logic [7:0] r, g, b, a;
    logic       last;
  } pixel_bytes_t;

  typedef struct {
    logic [127:0] data;
    logic         last;
    bit           typed;
    logic [31:0]  bytes;
  } stim_row_t;

  pixel_bytes_t     pending_px[$];
  tmap_pkg::cfg_t   shadow_cfg = tmap_pkg::CFG_RESET;
  logic [31:0]      log_rom[TAB_LEN];
  logic [31:0]      exp_rom[TAB_LEN];
  int               err_cnt = 0;
  int               cycle_cnt = 0;
  bit               calm_phase = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] xr, r, b;
    xr = x;
    r  = '0;
    b  = 64'h4000_0000_0000_0000;
    while (b > xr) b = b >> 2;
    while (b != 0) begin
      if (xr >= r + b) begin
        xr = xr - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Fill log2(1+x) and 2^x roms by exact integer steps
  task automatic build_roms();
    logic [63:0] root[TB_BITS+1];
    logic [63:0] m, e;
    logic [31:0] acc;
    root[0] = 64'h8000_0000;
    for (int k = 1; k <= TB_BITS; k++) root[k] = int_sqrt(root[k-1] << 30);
    for (int i = 0; i < TAB_LEN; i++) begin
      if (i == TAB_LEN - 1) begin
        log_rom[i] = 32'h4000_0000;
        exp_rom[i] = 32'h8000_0000;
      end else begin
        m   = 64'h4000_0000 + (64'(i) << (30 - TB_BITS));
        acc = '0;
        for (int k = 0; k < 30; k++) begin
          m   = (m * m) >> 30;
          acc = acc << 1;
          if (m >= 64'h8000_0000) begin
            acc[0] = 1'b1;
            m      = m >> 1;
          end
        end
        log_rom[i] = acc;
        e = 64'h4000_0000;
        for (int j = 0; j < TB_BITS; j++)
          if ((i >> j) & 1) e = (e * root[TB_BITS-j]) >> 30;
        exp_rom[i] = e[31:0];
      end
    end
  endtask

  function automatic logic [31:0] sat_q(input logic [63:0] v);
    return (v > SAT_MAX) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] rom_interp(input bit use_exp, input logic [31:0] f30);
    int          i;
    logic [63:0] rem, d;
    logic [31:0] lo, hi;
    i   = (f30 >> (30 - TB_BITS)) & (TAB_LEN - 2);
    rem = f30 & ((32'd1 << (30 - TB_BITS)) - 1);
    lo  = use_exp ? exp_rom[i] : log_rom[i];
    hi  = use_exp ? exp_rom[i+1] : log_rom[i+1];
    d   = 64'(hi - lo);
    return lo + 32'((d * rem) >> (30 - TB_BITS));
  endfunction

  function automatic longint q_log2(input logic [31:0] x);
    int          p;
    logic [31:0] m, lf;
    p = 31;
    while (p > 0 && !x[p]) p--;
    m  = (p <= 30) ? (x << (30 - p)) : (x >> 1);
    lf = rom_interp(1'b0, m - 32'h4000_0000);
    return longint'(p - FB) * (longint'(1) << FB) + longint'(lf >> (30 - FB));
  endfunction

  function automatic logic [31:0] q_exp2(input longint q);
    longint      n;
    logic [31:0] fr, mant;
    int          s;
    n = q >>> FB;
    if (n > 40) return 32'hFFFF_FFFF;
    if (n < -80) return 32'd0;
    fr   = 32'(q - (n << FB));
    mant = rom_interp(1'b1, fr << (30 - FB));
    s    = int'(n) + FB - 30;
    if (s >= 0) return sat_q(64'(mant) << s);
    if (-s >= 32) return 32'd0;
    return mant >> (-s);
  endfunction

  function automatic logic [31:0] scale_to_q(input logic [31:0] sig, input int k);
    int sh;
    sh = k + FB;
    if (sig == 0) return 32'd0;
    if (sh >= 32) return 32'hFFFF_FFFF;
    if (sh >= 0) return sat_q(64'(sig) << sh);
    if (-sh >= 32) return 32'd0;
    return sig >> (-sh);
  endfunction

  // Float bit pattern to unsigned Q; negatives and NaN give zero
  function automatic logic [31:0] float_to_q(input logic fmt, input logic [31:0] bits);
    logic [15:0] h;
    if (!fmt) begin
      h = bits[15:0];
      if (h[14:10] == 5'd31) return (h[9:0] != 0 || h[15]) ? 32'd0 : 32'hFFFF_FFFF;
      if (h[15]) return 32'd0;
      if (h[14:10] == 0) return scale_to_q(32'(h[9:0]), -24);
      return scale_to_q(32'({1'b1, h[9:0]}), int'(h[14:10]) - 25);
    end
    if (bits[30:23] == 8'd255) return (bits[22:0] != 0 || bits[31]) ? 32'd0 : 32'hFFFF_FFFF;
    if (bits[31]) return 32'd0;
    if (bits[30:23] == 0) return scale_to_q(32'(bits[22:0]), -149);
    return scale_to_q(32'({1'b1, bits[22:0]}), int'(bits[30:23]) - 150);
  endfunction

  function automatic logic [7:0] tone_map_channel(input tmap_pkg::cfg_t c,
                                                  input logic [31:0] bits);
    logic [31:0] v, t, kn, a, u;
    logic [63:0] ln, mag, prod, w;
    longint      p;
    v = float_to_q(c.fmt, bits);
    v = (v > c.defog) ? v - c.defog : 32'd0;
    v = sat_q((64'(v) * c.expo) >> FB);
    // Soft knee above the low level
    if (v > c.knee_low) begin
      t = v - c.knee_low;
      if (c.knee_fac == 0) begin
        kn = t;
      end else begin
        a  = sat_q((64'(t) * c.knee_fac) >> FB);
        u  = (a > 32'hFFFF_FFFF - (32'd1 << FB)) ? 32'hFFFF_FFFF : a + (32'd1 << FB);
        ln = (64'(q_log2(u)) * 64'(tmap_pkg::LN2_Q32)) >> 32;
        kn = sat_q((ln << FB) / c.knee_fac);
      end
      v = sat_q(64'(c.knee_low) + kn);
    end
    // Gamma as exp2(log2(v) * g)
    if (v != 0) begin
      p    = q_log2(v);
      mag  = 64'(p < 0 ? -p : p);
      prod = (mag * c.inv_gamma) >> FB;
      v    = q_exp2(p < 0 ? -longint'(prod) : longint'(prod));
    end
    w = (64'(v) * c.out_scale) >> (2 * FB);
    return (w > 255) ? 8'd255 : w[7:0];
  endfunction

  function automatic pixel_bytes_t tone_map_pixel(input tmap_pkg::cfg_t c,
                                                  input logic [127:0] d,
                                                  input logic last);
    pixel_bytes_t px;
    px.r    = tone_map_channel(c, d[31:0]);
    px.g    = tone_map_channel(c, d[63:32]);
    px.b    = tone_map_channel(c, d[95:64]);
    px.a    = tone_map_channel(c, d[127:96]);
    px.last = last;
    return px;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic int pick_gap();
    int r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] rand_channel(input logic fmt);
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 5))
          0: return fmt ? 32'h7F80_0000 : {16'($urandom_range(0, 65535)), 16'h7C00};
          1: return fmt ? 32'hFF80_0000 : 32'h0000_FC00;
          2: return fmt ? 32'h7FC0_0001 : 32'h0000_7E01;
          3: return fmt ? 32'h8000_0000 : 32'h0000_8000;
          4: return fmt ? 32'h7F7F_FFFF : 32'h0000_7BFF;
          default: return fmt ? 32'h0000_0001 : 32'h0000_0001;
        endcase
      end
      default: begin
        if (fmt) return {1'b0, 8'($urandom_range(105, 140)), 23'($urandom)};
        return {16'($urandom), 1'b0, 5'($urandom_range(6, 24)), 10'($urandom)};
      end
    endcase
  endfunction

  function automatic tmap_pkg::cfg_t rand_cfg();
    tmap_pkg::cfg_t c;
    c.fmt       = 1'($urandom);
    c.defog     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1 << 17) : 32'd0;
    c.expo      = $urandom_range(1 << 12, 1 << 22);
    c.knee_low  = $urandom_range(1 << 12, 1 << 20);
    c.knee_fac  = $urandom_range(1, 1 << 18);
    c.inv_gamma = $urandom_range(1 << 13, 1 << 17);
    c.out_scale = $urandom_range(1 << 20, 1 << 24);
    return c;
  endfunction

  // Write every register back to back, with an ignored write to an unused index
  task automatic load_cfg(input tmap_pkg::cfg_t c);
    logic [31:0] vals[7];
    vals = '{32'(c.fmt), c.defog, c.expo, c.knee_low, c.knee_fac, c.inv_gamma, c.out_scale};
    cfg_we <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_wdata <= $urandom;
    @(negedge clk);
    for (int i = tmap_pkg::REG_FORMAT; i <= tmap_pkg::REG_OUT_SCALE; i++) begin
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    shadow_cfg = c;
  endtask

  // Hold the request until taken, then log the expected bytes
  task automatic send_pixel(input logic [127:0] d, input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_px.push_back(tone_map_pixel(shadow_cfg, d, last));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic drain_pipe();
    in_tvalid <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 8) @(negedge clk);
  endtask

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  // ---------------------------------------------------------------- checker

  always @(negedge clk) out_tready <= calm_phase ? 1'b1 : (pick_gap() == 0);

  always @(posedge clk) begin
    pixel_bytes_t px;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_px.size() == 0) begin
        report("unexpected result", 32'd0, out_tdata);
      end else begin
        px = pending_px.pop_front();
        if (out_tdata[7:0] !== px.r) report("red", 32'(px.r), 32'(out_tdata[7:0]));
        if (out_tdata[15:8] !== px.g) report("green", 32'(px.g), 32'(out_tdata[15:8]));
        if (out_tdata[23:16] !== px.b) report("blue", 32'(px.b), 32'(out_tdata[23:16]));
        if (out_tdata[31:24] !== px.a) report("alpha", 32'(px.a), 32'(out_tdata[31:24]));
        if (out_tlast !== px.last) report("last", 32'(px.last), 32'(out_tlast));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  stim_row_t dir_rows[] = '{
    '{128'h0, 1'b0, 1'b1, 32'h0},
    '{{4{32'h0000_8000}}, 1'b0, 1'b1, 32'h0},
    '{{4{32'h0000_7E00}}, 1'b1, 1'b1, 32'h0},
    '{{4{32'h0000_FC00}}, 1'b0, 1'b1, 32'h0},
    '{{4{32'hFFFF_8000}}, 1'b0, 1'b1, 32'h0},
    '{{4{32'h0000_7C00}}, 1'b0, 1'b0, 32'h0},
    '{{4{32'h0000_7BFF}}, 1'b0, 1'b0, 32'h0},
    '{{4{32'hFFFF_7BFF}}, 1'b1, 1'b0, 32'h0},
    '{{4{32'h0000_0001}}, 1'b0, 1'b0, 32'h0},
    '{{4{32'h0000_03FF}}, 1'b0, 1'b0, 32'h0},
    '{{32'h0000_3C00, 32'h0000_4000, 32'h0000_3800, 32'h0000_4A00}, 1'b0, 1'b0, 32'h0},
    '{{32'h0000_5640, 32'h0000_2E66, 32'h0000_3555, 32'h0000_6000}, 1'b0, 1'b0, 32'h0},
    '{{32'hAAAA_3C00, 32'h5555_4400, 32'h1234_3400, 32'hFEDC_4C00}, 1'b1, 1'b0, 32'h0},
    '{{32'h0000_4400, 32'h0000_7C01, 32'h0000_3C00, 32'h0000_8001}, 1'b0, 1'b0, 32'h0}
  };

  initial begin
    tmap_pkg::cfg_t c;
    pixel_bytes_t px;
    build_roms();
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rows under the reset configuration
    foreach (dir_rows[i]) begin
      send_pixel(dir_rows[i].data, dir_rows[i].last);
      if (dir_rows[i].typed) begin
        px = pending_px[$];
        if ({px.a, px.b, px.g, px.r} !== dir_rows[i].bytes || px.last !== dir_rows[i].last)
          report("typed row", dir_rows[i].bytes, {px.a, px.b, px.g, px.r});
      end
    end
    drain_pipe();

    // Phases: corner configurations first, then random ones
    for (int ph = 0; ph < 10; ph++) begin
      c = rand_cfg();
      case (ph)
        0: c = '{1'b1, 32'd0, 32'd364089, 32'd65536, 32'd12124, 32'd29789, 32'd5547600};
        1: c = '{1'b0, 32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        2: c = '{1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0};
        3: c = '{1'b0, 32'd0, 32'd65536, 32'd65536, 32'd1, 32'd0, 32'd16711680};
        4: c = '{1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd12124, 32'd1, 32'hFFFF_FFFF};
        default: ;
      endcase
      calm_phase = (ph == 6);
      load_cfg(c);
      if (ph == 1) begin
        send_pixel({4{32'h0000_7C00}}, 1'b0);
        send_pixel({4{32'h0000_8000}}, 1'b1);
      end
      for (int n = 0; n < 115; n++) begin
        send_pixel({rand_channel(c.fmt), rand_channel(c.fmt), rand_channel(c.fmt),
                    rand_channel(c.fmt)}, ($urandom_range(0, 15) == 0));
        // Hold off mid-phase until the pipe has emptied
        if (ph == 7 && n == 50) begin
          in_tvalid <= 1'b0;
          while (pending_px.size() != 0) @(negedge clk);
        end
      end
      drain_pipe();
      calm_phase = 1'b0;
    end

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
